/* src/svalloc_pkg.sv */
package svalloc_pkg;

    // sizing
    localparam int KBD_VOICES  = 12;
    localparam int DRUM_VOICES = 5;

    localparam int KEY_W   = 7;
    localparam int NOTE_W  = 8;
    localparam int STAMP_W = 32;
    localparam int CHAN_W  = 3;
    localparam int VIDX_W  = 5;
    localparam int TABLE_W = 40;
    localparam int TABLE_ENTRIES = 5;

    localparam int IDX_W = (KBD_VOICES > 1) ? $clog2(KBD_VOICES) : 1;
    localparam int CNT_W = $clog2(KBD_VOICES + 1);

    // polyphony modes, clipped to the voice count
    localparam int POLY_LO = 6;
    localparam int POLY_HI = 12;
    localparam int ACTIVE_LO = (POLY_LO < KBD_VOICES) ? POLY_LO : KBD_VOICES;
    localparam int ACTIVE_HI = (POLY_HI < KBD_VOICES) ? POLY_HI : KBD_VOICES;

    localparam int RELEASED_BIT = NOTE_W - 1;

    // commands
    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    // register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRUM_TABLE  = 1'b1;

    // search record walking down the voice chain
    typedef struct packed {
        logic               valid;
        logic               off;
        logic [KEY_W-1:0]   key;
        logic               found;
        logic [IDX_W-1:0]   pick;
        logic [STAMP_W-1:0] stamp;
    } t_scan;

    // voice write-back, broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               rel;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_upd;

endpackage

/* src/svalloc_if.sv */
interface svalloc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic                         is_drum;
    logic [svalloc_pkg::KEY_W-1:0] key_number;

    modport source (output valid, output command, output is_drum, output key_number,
                    input ready);
    modport sink (input valid, input command, input is_drum, input key_number,
                  output ready);
endinterface

interface svalloc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          voice_found;
    logic [svalloc_pkg::VIDX_W-1:0] voice_index;
    logic [svalloc_pkg::NOTE_W-1:0] note_out;

    modport source (output valid, output voice_found, output voice_index, output note_out,
                    input ready);
    modport sink (input valid, input voice_found, input voice_index, input note_out,
                  output ready);
endinterface

/* src/svalloc_cell.sv */
module svalloc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [svalloc_pkg::IDX_W-1:0] i_index,
    input  logic                          i_active,
    input  svalloc_pkg::t_scan            i_scan,
    input  svalloc_pkg::t_upd             i_upd,
    output svalloc_pkg::t_scan            o_scan
);
    import svalloc_pkg::*;

    logic [NOTE_W-1:0]  r_note;
    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_scan;
    t_scan              n_scan;

    always_comb begin
        n_scan = i_scan;
        if (i_scan.valid && i_active) begin
            if (i_scan.off == CMD_NOTE_OFF) begin
                // first held voice with this exact note
                if (!i_scan.found && !r_note[RELEASED_BIT] &&
                    r_note[KEY_W-1:0] == i_scan.key) begin
                    n_scan.found = 1'b1;
                    n_scan.pick  = i_index;
                end
            end else begin
                // oldest free voice, strict compare keeps lowest index on ties
                if (r_note[RELEASED_BIT] && (!i_scan.found || r_stamp < i_scan.stamp)) begin
                    n_scan.found = 1'b1;
                    n_scan.pick  = i_index;
                    n_scan.stamp = r_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note  <= NOTE_W'(1) << RELEASED_BIT;
            r_stamp <= '0;
            r_scan  <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_upd.en && i_upd.idx == i_index) begin
                r_stamp <= i_upd.stamp;
                if (i_upd.rel) begin
                    r_note <= r_note | (NOTE_W'(1) << RELEASED_BIT);
                end else begin
                    r_note <= {1'b0, i_upd.key};
                end
            end
        end
    end

    assign o_scan = r_scan;

endmodule

/* src/synth_voice_allocator.sv */
// channel   dir  handshake     payload
// i_in      in   valid/ready   command, is_drum, key_number
// o_out     out  valid/ready   voice_found, voice_index, note_out
// i_cfg_*   in   write enable  register index, 40-bit data
//
// a drum request is resolved in the accept cycle and reaches o_out through the pending stage and the output register
// a keyboard request walks the row of voice cells, one cell per cycle, to resolve, then
// passes through the pending stage and the output register to reach o_out
// one request in flight; a finished result waits in a pending stage and the output
// register, and i_in stays blocked while the pending stage holds a result
// synchronous active-low reset frees every voice and clears stamps, drum busy bits,
// the event counter and both configuration registers
module synth_voice_allocator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    svalloc_req_if.sink                           i_in,
    svalloc_res_if.source                         o_out,
    input  logic                                  i_cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [svalloc_pkg::TABLE_W-1:0]       i_cfg_data
);
    import svalloc_pkg::*;

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    // configuration
    logic               r_poly;
    logic [TABLE_W-1:0] r_table;

    // control and shared state
    t_state                 r_state;
    logic [STAMP_W-1:0]     r_counter;
    logic [DRUM_VOICES-1:0] r_busy;
    t_scan                  r_inj;

    // pending result and output register
    logic              r_pend_valid;
    logic              r_pend_found;
    logic [VIDX_W-1:0] r_pend_idx;
    logic [NOTE_W-1:0] r_pend_note;
    logic              r_out_valid;
    logic              r_out_found;
    logic [VIDX_W-1:0] r_out_idx;
    logic [NOTE_W-1:0] r_out_note;

    // voice chain
    t_scan                 w_chain [KBD_VOICES+1];
    t_scan                 w_last;
    t_upd                  w_upd;
    logic [CNT_W-1:0]      w_active_n;
    logic [KBD_VOICES-1:0] w_active;

    // drum decode
    logic                   w_accept;
    logic [CHAN_W-1:0]      w_ch;
    logic                   w_ch_ok;
    logic                   w_tbl_ok;
    logic [DRUM_VOICES-1:0] w_mask;
    logic                   w_busy_hit;
    logic [TABLE_W-1:0]     w_tbl_shift;
    logic [NOTE_W-1:0]      w_key_note;
    logic [VIDX_W:0]        w_vsum;
    logic                   w_out_free;

    // configuration writes, out-of-range index has no register to hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= 1'b0;
            r_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POLY_SELECT: r_poly  <= i_cfg_data[0];
                REG_DRUM_TABLE:  r_table <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_pend_valid;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_key_note = {1'b0, i_in.key_number};

    // drum channel from the low key bits
    assign w_ch        = i_in.key_number[CHAN_W-1:0];
    assign w_ch_ok     = {1'b0, w_ch} < (CHAN_W+1)'(DRUM_VOICES);
    assign w_tbl_ok    = {1'b0, w_ch} < (CHAN_W+1)'(TABLE_ENTRIES);
    assign w_mask      = DRUM_VOICES'(1) << w_ch;
    assign w_busy_hit  = |(r_busy & w_mask);
    assign w_tbl_shift = r_table >> {w_ch, 3'b000};

    // active voices by polyphony mode; inactive cells just pass the record on
    assign w_active_n = r_poly ? CNT_W'(ACTIVE_HI) : CNT_W'(ACTIVE_LO);

    assign w_chain[0] = r_inj;

    for (genvar g = 0; g < KBD_VOICES; g++) begin : g_voice
        assign w_active[g] = CNT_W'(g) < w_active_n;

        svalloc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_active(w_active[g]),
            .i_scan  (w_chain[g]),
            .i_upd   (w_upd),
            .o_scan  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[KBD_VOICES];

    // write-back to the chosen voice as the record leaves the last cell
    always_comb begin
        w_upd.en    = (r_state == S_SCAN) && w_last.valid && w_last.found;
        w_upd.rel   = (w_last.off == CMD_NOTE_OFF);
        w_upd.idx   = w_last.pick;
        w_upd.key   = w_last.key;
        w_upd.stamp = r_counter;
    end

    assign w_vsum     = (VIDX_W+1)'(DRUM_VOICES) + (VIDX_W+1)'(w_last.pick);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_counter    <= '0;
            r_busy       <= '0;
            r_inj        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_inj.valid <= 1'b0;

            // drain pending result into the output register
            if (w_out_free) begin
                r_out_valid <= r_pend_valid;
                r_out_found <= r_pend_found;
                r_out_idx   <= r_pend_idx;
                r_out_note  <= r_pend_note;
                r_pend_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.is_drum) begin
                            r_counter    <= r_counter + 1'b1;
                            r_pend_valid <= 1'b1;
                            r_pend_found <= 1'b0;
                            r_pend_idx   <= '0;
                            r_pend_note  <= w_key_note;
                            if (w_ch_ok) begin
                                if (i_in.command == CMD_NOTE_ON) begin
                                    r_busy       <= r_busy | w_mask;
                                    r_pend_found <= 1'b1;
                                    r_pend_idx   <= VIDX_W'(w_ch);
                                    r_pend_note  <= w_tbl_ok ? w_tbl_shift[NOTE_W-1:0] : '0;
                                end else if (w_busy_hit) begin
                                    r_busy       <= r_busy & ~w_mask;
                                    r_pend_found <= 1'b1;
                                    r_pend_idx   <= VIDX_W'(w_ch);
                                end
                            end
                        end else begin
                            r_inj.valid <= 1'b1;
                            r_inj.off   <= i_in.command;
                            r_inj.key   <= i_in.key_number;
                            r_inj.found <= 1'b0;
                            r_inj.pick  <= '0;
                            r_inj.stamp <= '0;
                            r_state     <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_last.valid) begin
                        r_counter    <= r_counter + 1'b1;
                        r_pend_valid <= 1'b1;
                        r_pend_found <= w_last.found;
                        r_pend_idx   <= w_last.found ? w_vsum[VIDX_W-1:0] : '0;
                        r_pend_note  <= {1'b0, w_last.key};
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.voice_found = r_out_found;
    assign o_out.voice_index = r_out_idx;
    assign o_out.note_out    = r_out_note;

endmodule
